FILE: src/thnm_pkg.sv
// Shared types and constants of the trilinear hexahedron node mapping unit.
`timescale 1ns / 1ps

package thnm_pkg;

  // Element geometry.
  localparam int CORNER_COUNT = 8;
  localparam int IDX_W        = $clog2(CORNER_COUNT);
  localparam int AXES         = 3;

  // Fixed-point widths.
  localparam int COORD_W = 32;
  localparam int REF_W   = 16;
  localparam int FAC_W   = 16;  // 1 +- c, range 0 .. 2^15
  localparam int P1_W    = 31;  // product of two factors, up to 2^30
  localparam int WGT_W   = 46;  // corner weight, up to 2^45
  localparam int ACC_W   = 62;  // accumulators of the low and high halves

  // Action codes of an input request.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [2:0]                vertex_index;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [REF_W-1:0]   ref_r;
    logic signed [REF_W-1:0]   ref_s;
    logic signed [REF_W-1:0]   ref_t;
  } thnm_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } thnm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_wr;     // write one corner from the input request
    logic             eval_start;  // latch the reference node, clear accumulators
    logic             issue;       // feed one corner into the pipeline
    logic [IDX_W-1:0] issue_idx;
    logic             finish;      // round the sums into the output register
  } thnm_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } thnm_state_t;

endpackage

FILE: src/thnm_ctrl.sv
// Controller of the node mapping unit: sequences the corners of one evaluation.
`timescale 1ns / 1ps

module thnm_ctrl
  import thnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output thnm_cmd_t cmd
);

  localparam logic [IDX_W-1:0] LAST_CORNER = IDX_W'(CORNER_COUNT - 1);
  // Last count of the drain state, which waits until the product of the last issue sits in the accumulators.
  localparam logic [IDX_W-1:0] LAST_DRAIN  = IDX_W'(2);

  thnm_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.issue_idx = cnt_r;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_EVAL) begin
            cmd.eval_start = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_RUN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt_r == LAST_CORNER) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == LAST_DRAIN) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/thnm_datapath.sv
// Datapath of the node mapping unit: corner store, weight pipeline and accumulators.
`timescale 1ns / 1ps

module thnm_datapath
  import thnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  thnm_in_t  in_data,
  input  thnm_cmd_t cmd,
  output thnm_out_t out_data
);

  localparam logic signed [REF_W-1:0] ONE_Q14 = REF_W'(16384);
  localparam logic signed [REF_W-1:0] MONE_Q14 = -REF_W'(16384);
  // Bit i set means corner i takes the (1 + c) factor along that axis.
  localparam logic [CORNER_COUNT-1:0] SIGN_R = 8'b0110_0110;
  localparam logic [CORNER_COUNT-1:0] SIGN_S = 8'b1100_1100;
  localparam logic [CORNER_COUNT-1:0] SIGN_T = 8'b1111_0000;
  // Rounding offset of one half in units of 2^-45, folded into the low sum.
  localparam logic [ACC_W-1:0] LO_INIT = ACC_W'(1) << 44;

  function automatic logic signed [REF_W-1:0] sat_ref(input logic signed [REF_W-1:0] c);
    logic signed [REF_W-1:0] v;
    v = c;
    if (c > ONE_Q14) v = ONE_Q14;
    if (c < MONE_Q14) v = MONE_Q14;
    return v;
  endfunction

  function automatic logic [FAC_W-1:0] factor(input logic signed [REF_W-1:0] c,
                                              input logic plus);
    logic signed [REF_W:0] f;
    if (plus) f = $signed({ONE_Q14[REF_W-1], ONE_Q14}) + $signed({c[REF_W-1], c});
    else      f = $signed({ONE_Q14[REF_W-1], ONE_Q14}) - $signed({c[REF_W-1], c});
    return f[FAC_W-1:0];
  endfunction

  // Corner store, one array per axis.
  logic [COORD_W-1:0] store_r [AXES][CORNER_COUNT];

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      store_r[0][in_data.vertex_index] <= in_data.vertex_x;
      store_r[1][in_data.vertex_index] <= in_data.vertex_y;
      store_r[2][in_data.vertex_index] <= in_data.vertex_z;
    end
  end

  // Saturated reference node, latched at the start of an evaluation.
  logic signed [REF_W-1:0] r_r, s_r, t_r;

  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      r_r <= sat_ref(in_data.ref_r);
      s_r <= sat_ref(in_data.ref_s);
      t_r <= sat_ref(in_data.ref_t);
    end
  end

  // Stage A: product of the r and s factors, t factor and store read.
  logic               a_valid_r;
  logic [P1_W-1:0]    p1_r;
  logic [FAC_W-1:0]   ft_r;
  logic [COORD_W-1:0] a_coord_r [AXES];
  logic [2*FAC_W-1:0] p1_full;

  assign p1_full = factor(r_r, SIGN_R[cmd.issue_idx]) * factor(s_r, SIGN_S[cmd.issue_idx]);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p1_r <= p1_full[P1_W-1:0];
      ft_r <= factor(t_r, SIGN_T[cmd.issue_idx]);
      for (int k = 0; k < AXES; k++) begin
        a_coord_r[k] <= store_r[k][cmd.issue_idx];
      end
    end
  end

  // Stage B: full corner weight.
  logic                    b_valid_r;
  logic [WGT_W-1:0]        w_r;
  logic [COORD_W-1:0]      b_coord_r [AXES];
  logic [P1_W+FAC_W-1:0]   w_full;

  assign w_full = p1_r * ft_r;

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      w_r <= w_full[WGT_W-1:0];
      for (int k = 0; k < AXES; k++) begin
        b_coord_r[k] <= a_coord_r[k];
      end
    end
  end

  // Stage C: weight times the low and high halves of each coordinate.
  logic                    c_valid_r;
  logic [ACC_W-1:0]        prod_lo_r [AXES];
  logic signed [ACC_W-1:0] prod_hi_r [AXES];
  logic [WGT_W+16-1:0]     lo_full   [AXES];
  logic signed [WGT_W+16:0] hi_full  [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lo_full[k] = w_r * b_coord_r[k][15:0];
      hi_full[k] = $signed({1'b0, w_r}) * $signed(b_coord_r[k][31:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      for (int k = 0; k < AXES; k++) begin
        prod_lo_r[k] <= lo_full[k][ACC_W-1:0];
        prod_hi_r[k] <= hi_full[k][ACC_W-1:0];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= cmd.issue;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Accumulators, one low and one high sum per axis.
  logic [ACC_W-1:0]        lo_acc_r [AXES];
  logic signed [ACC_W-1:0] hi_acc_r [AXES];

  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      if (cmd.eval_start) begin
        lo_acc_r[k] <= LO_INIT;
        hi_acc_r[k] <= '0;
      end else if (c_valid_r) begin
        lo_acc_r[k] <= lo_acc_r[k] + prod_lo_r[k];
        hi_acc_r[k] <= hi_acc_r[k] + prod_hi_r[k];
      end
    end
  end

  // Final rounding: merge the halves and keep bits 60:29 of the sum.
  logic signed [ACC_W:0]   tot   [AXES];
  logic [COORD_W-1:0]      pos   [AXES];
  thnm_out_t               out_r;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      tot[k] = $signed({hi_acc_r[k][ACC_W-1], hi_acc_r[k]})
             + $signed({1'b0, {(16){1'b0}}, lo_acc_r[k][ACC_W-1:16]});
      pos[k] = tot[k][60:29];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.pos_x <= pos[0];
      out_r.pos_y <= pos[1];
      out_r.pos_z <= pos[2];
    end
  end

  assign out_data = out_r;

endmodule

FILE: src/trilinear_hex_node_mapping_unit.sv
// Top level of the trilinear hexahedron node mapping unit.
// A load request is written as it is accepted; the block can accept the next request right after it.
// An evaluate request goes in steps from acceptance to a valid result: the controller issues
// the eight corners one by one into the weight and multiply-accumulate pipeline, drains it and
// rounds; the next request is accepted after rounding, which waits until an earlier result is taken.
// Reset (rst_n low, synchronous) empties the pipeline and the output; corners stay unwritten.
`timescale 1ns / 1ps

module trilinear_hex_node_mapping_unit
  import thnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  thnm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output thnm_out_t out_data
);

  thnm_cmd_t cmd;

  // Sequencer.
  thnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  thnm_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

  // The output register is only loaded when it is free or being emptied.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // No request is accepted while corners are being issued.
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> in_stall)
    else $error("request accepted during an evaluation");

  // An evaluation starts issuing corners in the next cycle.
  a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval_start |=> (cmd.issue && cmd.issue_idx == '0))
    else $error("evaluation did not start with the first corner");

  // Rounding always produces a valid result.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("result not presented after rounding");

endmodule
